// ----- rtl/core/sltab_pkg.sv -----
// ----------------------------------------------------------------------------
// sltab_pkg: shared constants and types of the sorted list table
// Sizes, operation and status codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package sltab_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 5;
    localparam int OPCODE_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int CMP_W     = ((IDX_W > RANK_W) ? IDX_W : RANK_W) + 1;
    localparam int S_FIELD_W = OPCODE_W + VALUE_W + RANK_W;
    localparam int M_FIELD_W = VALUE_W + STATUS_W + 2;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] WIN_RESET = IDX_W'(CAPACITY / 2);
    localparam logic [IDX_W-1:0] WIN_LIMIT = IDX_W'(CAPACITY);

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_RANK  = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic scan;
        logic rm_take;
        logic shift;
        logic put;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    list_full;
        logic    rank_ok;
        logic    scan_stop;
        logic    shift_done;
    } sts_t;

endpackage

// ----- rtl/core/sltab_ram.sv -----
// ----------------------------------------------------------------------------
// sltab_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sltab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sltab_ctrl.sv -----
// ----------------------------------------------------------------------------
// sltab_ctrl: sequencer of the sorted list table
// Steps each operation through decode, then the scan, take, shift and write-back states it needs.
// ----------------------------------------------------------------------------
module sltab_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sltab_pkg::sts_t   sts,
    output sltab_pkg::cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_SCAN    = 7'b0000100,
        S_RM_TAKE = 7'b0001000,
        S_SHIFT   = 7'b0010000,
        S_PUT     = 7'b0100000,
        S_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                unique case (sts.op)
                    sltab_pkg::OP_INSERT: begin
                        state_next = sts.list_full ? S_FINISH : S_SCAN;
                    end
                    sltab_pkg::OP_LOOKUP: begin
                        state_next = S_SCAN;
                    end
                    sltab_pkg::OP_REMOVE: begin
                        state_next = sts.rank_ok ? S_RM_TAKE : S_FINISH;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_stop) begin
                    state_next = (sts.op == sltab_pkg::OP_LOOKUP) ? S_FINISH : S_SHIFT;
                end
            end
            S_RM_TAKE: begin
                cmd.rm_take = 1'b1;
                state_next  = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_done) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/sltab_dp.sv -----
// ----------------------------------------------------------------------------
// sltab_dp: datapath of the sorted list table
// Entry store, window bounds, scan pointer, shift engine and result register.
// ----------------------------------------------------------------------------
module sltab_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sltab_pkg::cmd_t                        cmd,
    output sltab_pkg::sts_t                        sts,
    input  logic [sltab_pkg::OPCODE_W-1:0]         in_opcode,
    input  logic signed [sltab_pkg::VALUE_W-1:0]   in_value,
    input  logic [sltab_pkg::RANK_W-1:0]           in_rank,
    output logic [sltab_pkg::M_TDATA_W-1:0]        out_data
);

    localparam int IW  = sltab_pkg::IDX_W;
    localparam int AW  = sltab_pkg::ADDR_W;
    localparam int CW  = sltab_pkg::CMP_W;
    localparam int VW  = sltab_pkg::VALUE_W;
    localparam int RW  = sltab_pkg::RANK_W;
    localparam int PAD = sltab_pkg::M_TDATA_W - sltab_pkg::M_FIELD_W;

    // window and shift control
    logic [IW-1:0] ws_reg, ws_next;
    logic [IW-1:0] we_reg, we_next;
    logic          pend_reg, pend_next;

    // item and working registers
    sltab_pkg::opcode_t   op_reg, op_next;
    logic signed [VW-1:0] val_reg, val_next;
    logic [RW-1:0]        rank_reg, rank_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [IW-1:0]        src_reg, src_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        wdst_reg, wdst_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic                 move_up_reg, move_up_next;
    logic                 adj_start_reg, adj_start_next;
    logic [VW-1:0]        res_value_reg, res_value_next;
    sltab_pkg::status_t   res_status_reg, res_status_next;
    logic [sltab_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    // store ports
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] wr_data, rd_data;
    logic [IW-1:0] rd_addr_full;

    // derived values
    logic [IW-1:0]        count, idx, found_rank;
    logic [CW-1:0]        rank_ext, count_ext;
    logic [IW:0]          win_sum;
    logic                 rank_ok, list_full, list_empty;
    logic                 scan_end, scan_hit, scan_stop, ins_lower, rm_lower;
    logic signed [VW-1:0] rd_signed;

    sltab_ram #(
        .WIDTH (VW),
        .DEPTH (sltab_pkg::CAPACITY)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign count      = we_reg - ws_reg;
    assign rank_ext   = CW'(rank_reg);
    assign count_ext  = CW'(count);
    assign rank_ok    = (rank_reg != '0) && (rank_ext <= count_ext);
    assign idx        = IW'(CW'(ws_reg) + rank_ext - CW'(1));
    assign win_sum    = (IW+1)'(ws_reg) + (IW+1)'(we_reg);
    assign list_full  = (ws_reg == '0) && (we_reg == sltab_pkg::WIN_LIMIT);
    assign list_empty = (ws_reg == we_reg);
    assign rd_signed  = $signed(rd_data);
    assign scan_end   = (k_reg == we_reg);
    assign scan_hit   = (op_reg == sltab_pkg::OP_INSERT) ? (val_reg < rd_signed)
                                                         : (rd_signed >= val_reg);
    assign scan_stop  = scan_end || scan_hit;
    assign ins_lower  = (({k_reg, 1'b1} <= win_sum) && (ws_reg != '0))
                        || (we_reg == sltab_pkg::WIN_LIMIT);
    assign rm_lower   = ({idx, 1'b1} <= win_sum);
    assign found_rank = k_reg - ws_reg + IW'(1);

    assign sts.op         = op_reg;
    assign sts.list_full  = list_full;
    assign sts.rank_ok    = rank_ok;
    assign sts.scan_stop  = scan_stop;
    assign sts.shift_done = (cnt_reg == '0);

    // read address: next element under test during the scan, source during the shift
    always_comb begin
        priority if (cmd.decode) begin
            rd_addr_full = (op_reg == sltab_pkg::OP_REMOVE) ? idx : ws_reg;
        end else if (cmd.scan) begin
            rd_addr_full = k_reg + IW'(1);
        end else if (cmd.shift) begin
            rd_addr_full = src_reg;
        end else begin
            rd_addr_full = ws_reg;
        end
    end
    assign rd_addr = rd_addr_full[AW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg[AW-1:0];
        wr_data = val_reg;
        if (cmd.shift && pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = wdst_reg[AW-1:0];
            wr_data = rd_data;
        end else if (cmd.put && (op_reg == sltab_pkg::OP_INSERT)) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        ws_next         = ws_reg;
        we_next         = we_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        rank_next       = rank_reg;
        k_next          = k_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        wdst_next       = wdst_reg;
        slot_next       = slot_reg;
        move_up_next    = move_up_reg;
        adj_start_next  = adj_start_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;

        if (cmd.accept) begin
            op_next   = sltab_pkg::opcode_t'(in_opcode);
            val_next  = in_value;
            rank_next = in_rank;
        end

        if (cmd.decode) begin
            k_next          = ws_reg;
            res_value_next  = '0;
            res_status_next = sltab_pkg::ST_OK;
            if ((op_reg == sltab_pkg::OP_INSERT) && list_full) begin
                res_status_next = sltab_pkg::ST_FULL;
            end else if ((op_reg == sltab_pkg::OP_REMOVE) && !rank_ok) begin
                res_status_next = sltab_pkg::ST_BAD_RANK;
            end
        end

        if (cmd.scan) begin
            if (!scan_stop) begin
                k_next = k_reg + IW'(1);
            end else if (op_reg == sltab_pkg::OP_LOOKUP) begin
                if (!scan_end && (rd_signed == val_reg)) begin
                    res_value_next  = VW'(found_rank);
                    res_status_next = sltab_pkg::ST_OK;
                end else begin
                    res_status_next = sltab_pkg::ST_NOT_FOUND;
                end
            end else begin
                pend_next = 1'b0;
                if (ins_lower) begin
                    src_next       = ws_reg;
                    move_up_next   = 1'b0;
                    cnt_next       = k_reg - ws_reg;
                    slot_next      = k_reg - IW'(1);
                    adj_start_next = 1'b1;
                end else begin
                    src_next       = we_reg - IW'(1);
                    move_up_next   = 1'b1;
                    cnt_next       = we_reg - k_reg;
                    slot_next      = k_reg;
                    adj_start_next = 1'b0;
                end
            end
        end

        if (cmd.rm_take) begin
            res_value_next = rd_data;
            pend_next      = 1'b0;
            if (rm_lower) begin
                src_next       = idx - IW'(1);
                move_up_next   = 1'b1;
                cnt_next       = idx - ws_reg;
                adj_start_next = 1'b1;
            end else begin
                src_next       = idx + IW'(1);
                move_up_next   = 1'b0;
                cnt_next       = we_reg - idx - IW'(1);
                adj_start_next = 1'b0;
            end
        end

        // one move per cycle: read the source, write it a slot further next cycle
        if (cmd.shift) begin
            if (cnt_reg != '0) begin
                src_next  = move_up_reg ? (src_reg - IW'(1)) : (src_reg + IW'(1));
                wdst_next = move_up_reg ? (src_reg + IW'(1)) : (src_reg - IW'(1));
                cnt_next  = cnt_reg - IW'(1);
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
        end

        if (cmd.put) begin
            if (op_reg == sltab_pkg::OP_INSERT) begin
                if (adj_start_reg) begin
                    ws_next = ws_reg - IW'(1);
                end else begin
                    we_next = we_reg + IW'(1);
                end
            end else begin
                if (adj_start_reg) begin
                    ws_next = ws_reg + IW'(1);
                end else begin
                    we_next = we_reg - IW'(1);
                end
            end
        end

        if (cmd.load_out) begin
            out_data_next = {{PAD{1'b0}}, list_full, list_empty, res_status_reg, res_value_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg   <= sltab_pkg::WIN_RESET;
            we_reg   <= sltab_pkg::WIN_RESET;
            pend_reg <= 1'b0;
        end else begin
            ws_reg   <= ws_next;
            we_reg   <= we_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        rank_reg       <= rank_next;
        k_reg          <= k_next;
        src_reg        <= src_next;
        cnt_reg        <= cnt_next;
        wdst_reg       <= wdst_next;
        slot_reg       <= slot_next;
        move_up_reg    <= move_up_next;
        adj_start_reg  <= adj_start_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

// ----- rtl/core/sorted_list_table.sv -----
// ----------------------------------------------------------------------------
// sorted_list_table: sorted list of signed values with insert, lookup, remove
// Values are kept in ascending order in a centred window of a small ram.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one beat per operation (opcode, item_value, rank)
//   m_ channel: exactly one result beat per operation
//   (result_value, status, is_empty, is_full)
//   steps: the scan reads one entry a cycle up to the insertion or match point
//   (removes skip it), and the shift moves one entry a cycle through the ram's
//   one write and one read port; refused operations skip the scan and shift
//   throughput: one operation at a time; s_tready is high only when idle
//   reset: the window becomes empty at the centre of the store, m_tvalid
//   drops; store contents are not cleared and need no clearing pass
//   stall: the result waits in the output register while m_tready is low;
//   a new beat is accepted meanwhile, and its result waits for the register
// ----------------------------------------------------------------------------
module sorted_list_table (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // opcode[1:0], item_value[33:2], rank[38:34], zero[39]
    input  logic [sltab_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_value[31:0], status[33:32], is_empty[34], is_full[35], zero[39:36]
    output logic [sltab_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int OW = sltab_pkg::OPCODE_W;
    localparam int VW = sltab_pkg::VALUE_W;
    localparam int RW = sltab_pkg::RANK_W;

    sltab_pkg::cmd_t cmd;
    sltab_pkg::sts_t sts;

    sltab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sltab_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_opcode (s_tdata[OW-1:0]),
        .in_value  ($signed(s_tdata[OW+VW-1:OW])),
        .in_rank   (s_tdata[OW+VW+RW-1:OW+VW]),
        .out_data  (m_tdata)
    );

endmodule

// ----- rtl/core/sltab_checker.sv -----
// ----------------------------------------------------------------------------
// sltab_checker: port-level checks of the sorted list table
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sltab_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sltab_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sltab_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int VW = sltab_pkg::VALUE_W;
    localparam int SW = sltab_pkg::STATUS_W;

    logic [SW-1:0] m_status;
    logic          m_empty, m_full;

    assign m_status = m_tdata[VW+SW-1:VW];
    assign m_empty  = m_tdata[VW+SW];
    assign m_full   = m_tdata[VW+SW+1];

    // no result beat straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // no beat taken back to back: s_tready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat accepted while busy");

    // the list is never empty and full at once
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_empty && m_full))
        else $error("result reports empty and full");

    // a refused insert reports a full list and no value
    a_full_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == sltab_pkg::ST_FULL) |-> m_full && (m_tdata[VW-1:0] == '0))
        else $error("full status without full list");

endmodule

bind sorted_list_table sltab_checker u_checker (.*);

// ----- verif/sorted_list_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_tb: self-checking bench for the sorted list table
// Drives insert, lookup and remove beats through the s_ stream and checks
// every m_ result beat in order against a predictor of the ordered window,
// under random stalls on both sides, a long output hold-off and source pauses.
// ----------------------------------------------------------------------------
module sorted_list_table_tb;

    localparam int CAPACITY       = sltab_pkg::CAPACITY;
    localparam int VALUE_W        = sltab_pkg::VALUE_W;
    localparam int RANK_W         = sltab_pkg::RANK_W;
    localparam int S_TDATA_W      = sltab_pkg::S_TDATA_W;
    localparam int M_TDATA_W      = sltab_pkg::M_TDATA_W;
    localparam int CLK_HALF       = 6;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [VALUE_W-1:0] value;
        sltab_pkg::status_t status;
        logic               empty;
        logic               full;
    } list_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // predictor state: ordered entries live in list_slots[win_lo .. win_hi-1]
    logic signed [VALUE_W-1:0] list_slots [CAPACITY];
    int                        win_lo = CAPACITY / 2;
    int                        win_hi = CAPACITY / 2;
    list_result_t              expected_results [$];

    logic tx_idle_on  = 1'b1;
    logic rx_idle_on  = 1'b1;
    logic rx_hold_req = 1'b0;

    int mismatch_count = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    int op_count [3] = '{0, 0, 0};
    int status_count [4] = '{0, 0, 0, 0};

    sorted_list_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic list_result_t apply_list_op(input sltab_pkg::opcode_t op,
                                                   input logic signed [VALUE_W-1:0] val,
                                                   input logic [RANK_W-1:0] rk);
        list_result_t res;
        int pos;
        int mid;
        int idx;
        res.value  = '0;
        res.status = sltab_pkg::ST_OK;
        mid = (win_lo + win_hi - 1) / 2;
        case (op)
            sltab_pkg::OP_INSERT: begin
                if (win_lo == 0 && win_hi == CAPACITY) begin
                    res.status = sltab_pkg::ST_FULL;
                end else begin
                    pos = win_lo;
                    while (pos < win_hi && val >= list_slots[pos]) pos++;
                    if ((pos <= mid && win_lo > 0) || win_hi == CAPACITY) begin
                        for (int i = win_lo; i < pos; i++) list_slots[i-1] = list_slots[i];
                        list_slots[pos-1] = val;
                        win_lo--;
                    end else begin
                        for (int i = win_hi; i > pos; i--) list_slots[i] = list_slots[i-1];
                        list_slots[pos] = val;
                        win_hi++;
                    end
                end
            end
            sltab_pkg::OP_LOOKUP: begin
                pos = win_lo;
                while (pos < win_hi && list_slots[pos] < val) pos++;
                if (pos < win_hi && list_slots[pos] == val)
                    res.value = VALUE_W'(pos - win_lo + 1);
                else
                    res.status = sltab_pkg::ST_NOT_FOUND;
            end
            sltab_pkg::OP_REMOVE: begin
                if (rk == 0 || int'(rk) > win_hi - win_lo) begin
                    res.status = sltab_pkg::ST_BAD_RANK;
                end else begin
                    idx = win_lo + int'(rk) - 1;
                    res.value = list_slots[idx];
                    if (idx <= mid) begin
                        for (int i = idx; i > win_lo; i--) list_slots[i] = list_slots[i-1];
                        win_lo++;
                    end else begin
                        for (int i = idx; i + 1 < win_hi; i++) list_slots[i] = list_slots[i+1];
                        win_hi--;
                    end
                end
            end
            default: ;
        endcase
        res.empty = (win_lo == win_hi);
        res.full  = (win_lo == 0 && win_hi == CAPACITY);
        op_count[op]++;
        status_count[res.status]++;
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            1, 2, 3, 4: v = $signed(VALUE_W'($urandom_range(0, 15))) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_list_op(input sltab_pkg::opcode_t op,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [RANK_W-1:0] rk);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({rk, val, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(apply_list_op(op, val, rk));
    endtask

    task automatic send_random_op(input int ins_pct, input int look_pct);
        int pick;
        int count;
        logic signed [VALUE_W-1:0] val;
        logic [RANK_W-1:0] rk;
        pick  = $urandom_range(0, 99);
        count = win_hi - win_lo;
        rk    = RANK_W'($urandom_range(0, CAPACITY));
        val   = rand_value();
        if (pick < ins_pct) begin
            send_list_op(sltab_pkg::OP_INSERT, val, rk);
        end else if (pick < ins_pct + look_pct) begin
            if (count > 0 && $urandom_range(0, 9) < 6)
                val = list_slots[win_lo + $urandom_range(0, count - 1)];
            send_list_op(sltab_pkg::OP_LOOKUP, val, rk);
        end else begin
            if (count > 0 && $urandom_range(0, 99) < 85)
                rk = RANK_W'($urandom_range(1, count));
            send_list_op(sltab_pkg::OP_REMOVE, val, rk);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_list();
        send_list_op(sltab_pkg::OP_LOOKUP, 32'sd0, 5'd0);
        send_list_op(sltab_pkg::OP_REMOVE, 32'sd0, 5'd1);
        send_list_op(sltab_pkg::OP_REMOVE, -32'sd1, 5'd0);
    endtask

    task automatic test_fill_extremes();
        logic signed [VALUE_W-1:0] fill_vals [CAPACITY] = '{
            32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 5, 5, 5,
            -5, 100, -100, 32'sh4000_0000, 32'shc000_0000, 7, 7, 2
        };
        foreach (fill_vals[i]) send_list_op(sltab_pkg::OP_INSERT, fill_vals[i], RANK_W'(i));
        // one more insert is refused once every slot is taken
        send_list_op(sltab_pkg::OP_INSERT, 32'sd3, 5'd31);
        send_list_op(sltab_pkg::OP_LOOKUP, 32'sd5, 5'd0);
        send_list_op(sltab_pkg::OP_LOOKUP, 32'sh7fff_ffff, 5'd0);
        send_list_op(sltab_pkg::OP_REMOVE, 32'sd0, 5'd16);
        send_list_op(sltab_pkg::OP_REMOVE, 32'sd0, 5'd16);
        send_list_op(sltab_pkg::OP_REMOVE, 32'sd0, 5'd0);
        wait_results_drained();
    endtask

    task automatic test_fill_drain_rounds();
        repeat (8) begin
            while (win_hi - win_lo < CAPACITY) send_random_op(80, 20);
            send_random_op(100, 0);
            while (win_hi - win_lo > 0) send_random_op(0, 20);
        end
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        rx_hold_req <= 1'b1;
        repeat (10) send_random_op(50, 25);
        wait_results_drained();
    endtask

    task automatic test_source_pause();
        repeat (4) begin
            repeat ($urandom_range(3, 8)) send_random_op(40, 25);
            wait_results_drained();
        end
    endtask

    task automatic test_random_ops();
        for (int i = 0; i < 900; i++) begin
            if (i % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_op(40, 25);
        end
        wait_results_drained();
    endtask

    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (150) send_random_op(40, 25);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                m_tready    <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.value  = m_tdata[31:0];
            got.status = sltab_pkg::status_t'(m_tdata[33:32]);
            got.empty  = m_tdata[34];
            got.full   = m_tdata[35];
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result beat value=%h status=%s empty=%b full=%b",
                             $realtime, got.value, got.status.name(), got.empty, got.full);
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value || got.status !== want.status ||
                    got.empty !== want.empty || got.full !== want.full) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: result mismatch exp value=%h status=%s empty=%b ",
                                  "full=%b, got value=%h status=%s empty=%b full=%b"},
                                 $realtime, want.value, want.status.name(), want.empty,
                                 want.full, got.value, got.status.name(), got.empty, got.full);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, quiet_cycles);
            $display("sorted_list_table_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_list();
        test_fill_extremes();
        test_fill_drain_rounds();
        test_output_backpressure();
        test_source_pause();
        test_random_ops();
        test_steady_stream();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) mismatch_count++;
        $display("covered %0d inserts, %0d lookups, %0d removes;",
                 op_count[sltab_pkg::OP_INSERT], op_count[sltab_pkg::OP_LOOKUP],
                 op_count[sltab_pkg::OP_REMOVE]);
        $display("%0d refused as full, %0d misses, %0d bad ranks, %0d beats, %0d mismatches",
                 status_count[sltab_pkg::ST_FULL], status_count[sltab_pkg::ST_NOT_FOUND],
                 status_count[sltab_pkg::ST_BAD_RANK], results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("sorted_list_table_tb: done, clean");
        end else begin
            $display("sorted_list_table_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sorted_list_table.f -----
rtl/core/sltab_pkg.sv
rtl/core/sltab_ram.sv
rtl/core/sltab_ctrl.sv
rtl/core/sltab_dp.sv
rtl/core/sorted_list_table.sv
rtl/core/sltab_checker.sv
verif/sorted_list_table_tb.sv
